// ===== sv/ecpa_pkg.sv =====
// Package for the elliptic curve point add/double block.
// Holds field width, command and status types shared by controller and datapath.
`default_nettype none
package ecpa_pkg;
  localparam int FIELD_W = 16;
  localparam logic [0:0] REG_MODULUS = 1'b0;
  localparam logic [0:0] REG_CURVE_A = 1'b1;

  // datapath micro-operations
  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_RED   = 4'd2;
  localparam logic [3:0] OP_MUL   = 4'd3;
  localparam logic [3:0] OP_ADD   = 4'd4;
  localparam logic [3:0] OP_SUB   = 4'd5;
  localparam logic [3:0] OP_INVS  = 4'd6;
  localparam logic [3:0] OP_INVI  = 4'd7;
  localparam logic [3:0] OP_MOV   = 4'd8;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] dst;
    logic [2:0] sa;
    logic [2:0] sb;
  } ecpa_cmd_t;

  typedef struct packed {
    logic busy;
    logic inv_done;
    logic inv_ok;
    logic mod_small;
  } ecpa_sts_t;

  // register file slots
  localparam logic [2:0] R_X1 = 3'd0;
  localparam logic [2:0] R_Y1 = 3'd1;
  localparam logic [2:0] R_X2 = 3'd2;
  localparam logic [2:0] R_Y2 = 3'd3;
  localparam logic [2:0] R_A  = 3'd4;
  localparam logic [2:0] R_T  = 3'd5;
  localparam logic [2:0] R_U  = 3'd6;
  localparam logic [2:0] R_S  = 3'd7;
endpackage
`default_nettype wire

// ===== sv/ecpa_datapath.sv =====
// Datapath: eight-entry field register file, multi-cycle modular reduce/multiply,
// and an extended Euclid inverse unit. Depends on ecpa_pkg.
`default_nettype none
module ecpa_datapath
  import ecpa_pkg::*;
#(
  parameter int W = FIELD_W
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic [W-1:0] modulus,
  input  wire logic [W-1:0] curve_a,
  input  wire logic [W-1:0] ld_px,
  input  wire logic [W-1:0] ld_py,
  input  wire logic [W-1:0] ld_qx,
  input  wire logic [W-1:0] ld_qy,
  input  wire ecpa_cmd_t    cmd,
  input  wire logic         cmd_valid,
  output ecpa_sts_t         sts,
  output logic [W-1:0]      rd_x,
  output logic [W-1:0]      rd_y
);
  localparam int CW = $clog2(2*W+2);

  logic [W-1:0] rf_r [8];
  logic [W-1:0] a_v, b_v;
  assign a_v = rf_r[cmd.sa];
  assign b_v = rf_r[cmd.sb];
  assign rd_x = rf_r[R_X1];
  assign rd_y = rf_r[R_Y1];

  // restoring remainder of a 2W-bit value, one bit per cycle
  logic [2*W-1:0] num_r, num_nxt;
  logic [W:0]     rem_r, rem_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [2:0]     dst_r, dst_nxt;
  logic           rbusy_r, rbusy_nxt;
  logic [W:0]     shl;

  // inverse unit: r0,r1,t0,t1 with quotient bits produced by long division
  logic           ibusy_r, ibusy_nxt;
  logic [1:0]     iph_r, iph_nxt;
  logic [W:0]     r0_r, r0_nxt, r1_r, r1_nxt;
  logic [W-1:0]   t0_r, t0_nxt, t1_r, t1_nxt;
  logic [W-1:0]   q_r, q_nxt;
  logic [W:0]     qr_r, qr_nxt;
  logic [CW-1:0]  qc_r, qc_nxt;
  logic [W-1:0]   acc_r, acc_nxt;
  logic           idone_r, idone_nxt, iok_r, iok_nxt;
  logic [W:0]     qshl;
  logic [W:0]     acc2, acc3;
  logic [W-1:0]   accm, accm2;

  logic [W:0]     sum, dif;
  logic [2*W-1:0] prod;

  always_comb begin
    sum  = {1'b0, a_v} + {1'b0, b_v};
    dif  = {1'b0, a_v} + {1'b0, modulus} - {1'b0, b_v};
    prod = a_v * b_v;
    shl  = {rem_r[W-1:0], num_r[2*W-1]};
    qshl = {qr_r[W-1:0], r0_r[W-1]};
    acc2 = {acc_r, 1'b0};
    accm = (acc2 >= {1'b0, modulus}) ? W'(acc2 - {1'b0, modulus}) : acc2[W-1:0];
    acc3 = {1'b0, accm} + {1'b0, t1_r};
    accm2 = (acc3 >= {1'b0, modulus}) ? W'(acc3 - {1'b0, modulus}) : acc3[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd.op == OP_LOAD) begin
      rf_r[R_X1] <= ld_px;
      rf_r[R_Y1] <= ld_py;
      rf_r[R_X2] <= ld_qx;
      rf_r[R_Y2] <= ld_qy;
      rf_r[R_A]  <= curve_a;
    end else if (cmd_valid && cmd.op == OP_ADD) begin
      rf_r[cmd.dst] <= (sum >= {1'b0, modulus}) ? W'(sum - {1'b0, modulus}) : sum[W-1:0];
    end else if (cmd_valid && cmd.op == OP_SUB) begin
      rf_r[cmd.dst] <= (dif >= {1'b0, modulus}) ? W'(dif - {1'b0, modulus}) : dif[W-1:0];
    end else if (cmd_valid && cmd.op == OP_MOV) begin
      rf_r[cmd.dst] <= a_v;
    end else if (cmd_valid && cmd.op == OP_INVI) begin
      rf_r[cmd.dst] <= iok_r ? t0_r : '0;
    end else if (rbusy_r && cnt_r == CW'(1)) begin
      rf_r[dst_r] <= rem_nxt[W-1:0];
    end
  end

  always_comb begin
    num_nxt = num_r; rem_nxt = rem_r; cnt_nxt = cnt_r; dst_nxt = dst_r; rbusy_nxt = rbusy_r;
    if (rbusy_r) begin
      rem_nxt = (shl >= {1'b0, modulus}) ? shl - {1'b0, modulus} : shl;
      num_nxt = {num_r[2*W-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) rbusy_nxt = 1'b0;
    end else if (cmd_valid && (cmd.op == OP_MUL || cmd.op == OP_RED)) begin
      num_nxt = (cmd.op == OP_MUL) ? prod : {{W{1'b0}}, a_v};
      rem_nxt = '0;
      cnt_nxt = CW'(2*W);
      dst_nxt = cmd.dst;
      rbusy_nxt = 1'b1;
    end
  end

  always_comb begin
    ibusy_nxt = ibusy_r; iph_nxt = iph_r; r0_nxt = r0_r; r1_nxt = r1_r;
    t0_nxt = t0_r; t1_nxt = t1_r; q_nxt = q_r; qr_nxt = qr_r; qc_nxt = qc_r;
    acc_nxt = acc_r; idone_nxt = 1'b0; iok_nxt = iok_r;
    if (!ibusy_r) begin
      if (cmd_valid && cmd.op == OP_INVS) begin
        ibusy_nxt = 1'b1; iph_nxt = 2'd0;
        r0_nxt = {1'b0, modulus}; r1_nxt = {1'b0, a_v};
        t0_nxt = '0; t1_nxt = W'(1);
      end
    end else begin
      unique case (iph_r)
        2'd0: begin
          if (r1_r == '0) begin
            ibusy_nxt = 1'b0; idone_nxt = 1'b1;
            iok_nxt = (r0_r == (W+1)'(1));
          end else begin
            iph_nxt = 2'd1; qr_nxt = '0; q_nxt = '0; qc_nxt = CW'(W);
          end
        end
        2'd1: begin
          // one quotient bit per cycle; r0 shifts out through its top
          if (qshl >= r1_r) begin
            qr_nxt = qshl - r1_r; q_nxt = {q_r[W-2:0], 1'b1};
          end else begin
            qr_nxt = qshl; q_nxt = {q_r[W-2:0], 1'b0};
          end
          r0_nxt = {1'b0, r0_r[W-2:0], 1'b0};
          qc_nxt = qc_r - CW'(1);
          if (qc_r == CW'(1)) begin
            iph_nxt = 2'd2; acc_nxt = '0; qc_nxt = CW'(W);
          end
        end
        2'd2: begin
          // q*t1 mod m by double and add, quotient msb first
          acc_nxt = q_r[W-1] ? accm2 : accm;
          q_nxt = {q_r[W-2:0], 1'b0};
          qc_nxt = qc_r - CW'(1);
          if (qc_r == CW'(1)) iph_nxt = 2'd3;
        end
        default: begin
          r0_nxt = r1_r; r1_nxt = qr_r;
          t0_nxt = t1_r;
          t1_nxt = (t0_r >= acc_r) ? t0_r - acc_r : W'({1'b0, t0_r} + {1'b0, modulus} - {1'b0, acc_r});
          iph_nxt = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rbusy_r <= 1'b0; ibusy_r <= 1'b0; idone_r <= 1'b0; iok_r <= 1'b0; iph_r <= 2'd0;
    end else begin
      rbusy_r <= rbusy_nxt; ibusy_r <= ibusy_nxt; idone_r <= idone_nxt;
      iok_r <= iok_nxt; iph_r <= iph_nxt;
    end
    num_r <= num_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt; dst_r <= dst_nxt;
    r0_r <= r0_nxt; r1_r <= r1_nxt; t0_r <= t0_nxt; t1_r <= t1_nxt;
    q_r <= q_nxt; qr_r <= qr_nxt; qc_r <= qc_nxt; acc_r <= acc_nxt;
  end

  assign sts.busy      = rbusy_r | ibusy_r;
  assign sts.inv_done  = idone_r;
  assign sts.inv_ok    = iok_r;
  assign sts.mod_small = (modulus < W'(2));

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(rbusy_r && ibusy_r)) else $error("reduce and inverse both busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    idone_r |=> !idone_r) else $error("inverse done held");
  a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
    idone_r |-> $past(ibusy_r)) else $error("inverse done without run");
endmodule
`default_nettype wire

// ===== sv/ecpa_ctrl.sv =====
// Controller: microprogram sequencer issuing datapath commands per item.
// Depends on ecpa_pkg.
`default_nettype none
module ecpa_ctrl
  import ecpa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic dbl,
  input  wire logic out_free,
  input  wire ecpa_sts_t sts,
  output ecpa_cmd_t cmd,
  output logic      cmd_valid,
  output logic      idle,
  output logic      done,
  output logic      flag
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] st_r, st_nxt;
  logic [4:0] pc_r, pc_nxt;
  logic       dbl_r, dbl_nxt, fl_r, fl_nxt;
  ecpa_cmd_t  uc;
  logic       last;

  function automatic ecpa_cmd_t mk(input logic [3:0] o, input logic [2:0] d,
                                   input logic [2:0] a, input logic [2:0] b);
    ecpa_cmd_t c;
    c.op = o; c.dst = d; c.sa = a; c.sb = b;
    return c;
  endfunction

  always_comb begin
    last = 1'b0;
    uc = mk(OP_NONE, R_T, R_T, R_T);
    unique case (pc_r)
      5'd0: uc = mk(OP_LOAD, R_X1, R_X1, R_X1);
      5'd1: uc = mk(OP_RED, R_X1, R_X1, R_X1);
      5'd2: uc = mk(OP_RED, R_Y1, R_Y1, R_Y1);
      5'd3: uc = mk(OP_RED, R_X2, R_X2, R_X2);
      5'd4: uc = mk(OP_RED, R_Y2, R_Y2, R_Y2);
      5'd5: uc = mk(OP_RED, R_A, R_A, R_A);
      5'd6: uc = dbl_r ? mk(OP_MOV, R_X2, R_X1, R_X1) : mk(OP_SUB, R_T, R_Y2, R_Y1);
      5'd7: uc = dbl_r ? mk(OP_MUL, R_T, R_X1, R_X1) : mk(OP_SUB, R_U, R_X2, R_X1);
      5'd8: uc = dbl_r ? mk(OP_ADD, R_U, R_T, R_T) : mk(OP_NONE, R_T, R_T, R_T);
      5'd9: uc = dbl_r ? mk(OP_ADD, R_T, R_U, R_T) : mk(OP_NONE, R_T, R_T, R_T);
      5'd10: uc = dbl_r ? mk(OP_ADD, R_T, R_T, R_A) : mk(OP_NONE, R_T, R_T, R_T);
      5'd11: uc = dbl_r ? mk(OP_ADD, R_U, R_Y1, R_Y1) : mk(OP_NONE, R_T, R_T, R_T);
      5'd12: uc = mk(OP_INVS, R_U, R_U, R_U);
      5'd13: uc = mk(OP_INVI, R_U, R_U, R_U);
      5'd14: uc = mk(OP_MUL, R_S, R_T, R_U);
      5'd15: uc = mk(OP_MUL, R_T, R_S, R_S);
      5'd16: uc = mk(OP_SUB, R_T, R_T, R_X1);
      5'd17: uc = mk(OP_SUB, R_T, R_T, R_X2);
      5'd18: uc = mk(OP_SUB, R_U, R_X1, R_T);
      5'd19: uc = mk(OP_MOV, R_X1, R_T, R_T);
      5'd20: uc = mk(OP_MUL, R_U, R_S, R_U);
      5'd21: begin
        uc = mk(OP_SUB, R_Y1, R_U, R_Y1);
        last = 1'b1;
      end
      default: uc = mk(OP_NONE, R_T, R_T, R_T);
    endcase
  end

  always_comb begin
    st_nxt = st_r; pc_nxt = pc_r; dbl_nxt = dbl_r; fl_nxt = fl_r;
    cmd = uc; cmd_valid = 1'b0;
    unique case (st_r)
      S_IDLE: if (in_fire) begin
        st_nxt = S_ISSUE; pc_nxt = '0; dbl_nxt = dbl; fl_nxt = 1'b0;
      end
      S_ISSUE: begin
        cmd_valid = 1'b1;
        if (pc_r == 5'd1 && sts.mod_small) begin
          cmd_valid = 1'b0; fl_nxt = 1'b1; st_nxt = S_DONE;
        end else begin
          st_nxt = S_WAIT;
        end
      end
      S_WAIT: if (!sts.busy) begin
        if (pc_r == 5'd13) fl_nxt = !sts.inv_ok;
        if (last) st_nxt = S_DONE;
        else begin
          pc_nxt = pc_r + 5'd1; st_nxt = S_ISSUE;
        end
      end
      S_DONE: if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; pc_r <= '0; dbl_r <= 1'b0; fl_r <= 1'b0;
    end else begin
      st_r <= st_nxt; pc_r <= pc_nxt; dbl_r <= dbl_nxt; fl_r <= fl_nxt;
    end
  end

  assign idle = (st_r == S_IDLE);
  assign done = (st_r == S_DONE) && out_free;
  assign flag = fl_r;

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> st_r == S_IDLE) else $error("item taken while busy");
  a_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid |-> !sts.busy) else $error("command issued while unit busy");
  a_pc: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= 5'd21) else $error("sequencer out of range");
endmodule
`default_nettype wire

// ===== sv/ec_point_add_double_mod_p.sv =====
// Each beat runs a fixed microprogram. Every modular reduce or multiply holds the
// sequencer until the unit is done: eight of them when adding, nine when doubling.
// The inverse loop runs Euclid steps one after another until the remainder is zero.
// One item is in work at a time, and the result register frees the input side once
// loaded. A modulus below 2 returns zeros with no_inverse set. The modular
// reduce/multiply unit and the bit-serial Euclid unit set the rate. Depends on
// ecpa_pkg, ecpa_ctrl, ecpa_datapath.
`default_nettype none
module ec_point_add_double_mod_p
  import ecpa_pkg::*;
#(
  parameter int FIELD_WIDTH = FIELD_W
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [0:0]                 cfg_index,
  input  wire logic [FIELD_WIDTH-1:0]     cfg_data,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // op, px, py, qx, qy from bit 0 up
  input  wire logic [((4*FIELD_WIDTH+8)/8)*8-1:0] in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // rx, ry, no_inverse from bit 0 up
  output logic [((2*FIELD_WIDTH+8)/8)*8-1:0] out_tdata
);
  localparam int W = FIELD_WIDTH;
  localparam int OW = ((2*W+8)/8)*8;

  logic [W-1:0] mod_r, ca_r;
  ecpa_cmd_t cmd;
  logic cmd_valid, idle, done, flag;
  ecpa_sts_t sts;
  logic [W-1:0] rd_x, rd_y;
  logic ov_r;
  logic [OW-1:0] od_r;
  logic in_fire;
  logic [4*W-1:0] ip_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= W'(2); ca_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODULUS: mod_r <= cfg_data;
        REG_CURVE_A: ca_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = idle;
  assign in_fire = in_tvalid && in_tready;

  // hold the accepted coordinates for the load step
  always_ff @(posedge clk) begin
    if (in_fire) ip_r <= in_tdata[4*W:1];
  end

  ecpa_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .dbl(in_tdata[0]), .out_free(!ov_r || out_tready),
    .sts, .cmd, .cmd_valid, .idle, .done, .flag
  );

  ecpa_datapath #(.W(W)) u_dp (
    .clk, .rst_n, .modulus(mod_r), .curve_a(ca_r),
    .ld_px(ip_r[W-1:0]), .ld_py(ip_r[2*W-1:W]),
    .ld_qx(ip_r[3*W-1:2*W]), .ld_qy(ip_r[4*W-1:3*W]),
    .cmd, .cmd_valid, .sts, .rd_x, .rd_y
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (done) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
    if (done) od_r <= flag && sts.mod_small
                      ? OW'({1'b1, {(2*W){1'b0}}})
                      : OW'({flag, rd_y, rd_x});
  end
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_tready |=> ov_r) else $error("result dropped");
  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    !idle |-> !in_tready) else $error("input open while busy");
  a_mod_small: assert property (@(posedge clk) disable iff (!rst_n)
    done && sts.mod_small |-> flag) else $error("small modulus not flagged");
endmodule
`default_nettype wire

// ===== dv/ecpa_checker.sv =====
// Checker for the point add/double block: watches the config, input and result
// channels, predicts each result and compares it field by field. Depends on ecpa_pkg.
`default_nettype none
module ecpa_checker
  import ecpa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [71:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,
  output int               fail_count,
  output int               pending
);
  typedef struct packed {
    logic        no_inv;
    logic [15:0] ry;
    logic [15:0] rx;
  } point_res_t;

  logic [15:0] field_mod;
  logic [15:0] coef_a;
  point_res_t  expected_points[$];

  assign pending = expected_points.size();

  function automatic longint unsigned msub(longint unsigned x, longint unsigned y,
                                           longint unsigned m);
    return (x + m - y) % m;
  endfunction

  function automatic point_res_t predict_point(logic [71:0] d);
    longint unsigned m, x1, y1, x2, y2, a, num, den, s, x3, y3;
    longint unsigned r0, r1, r2, t0, t1, t2, q, inv;
    point_res_t res;
    m = field_mod;
    if (m < 2) begin
      res.rx = '0;
      res.ry = '0;
      res.no_inv = 1'b1;
      return res;
    end
    x1 = d[16:1] % m;
    y1 = d[32:17] % m;
    x2 = d[48:33] % m;
    y2 = d[64:49] % m;
    a  = coef_a % m;
    if (d[0]) begin
      x2  = x1;
      num = ((3 % m) * ((x1 * x1) % m) % m + a) % m;
      den = ((2 % m) * y1) % m;
    end else begin
      num = msub(y2, y1, m);
      den = msub(x2, x1, m);
    end
    r0 = m;
    r1 = den;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q  = r0 / r1;
      r2 = r0 - q * r1;
      t2 = msub(t0, ((q % m) * t1) % m, m);
      r0 = r1;
      r1 = r2;
      t0 = t1;
      t1 = t2;
    end
    res.no_inv = (r0 != 1);
    inv = res.no_inv ? 0 : t0 % m;
    s  = (num * inv) % m;
    x3 = msub(msub((s * s) % m, x1, m), x2, m);
    y3 = msub((s * msub(x1, x3, m)) % m, y1, m);
    res.rx = x3[15:0];
    res.ry = y3[15:0];
    return res;
  endfunction

  always @(posedge clk) begin
    point_res_t exp_pt;
    point_res_t got_pt;
    if (!rst_n) begin
      field_mod <= 16'd2;
      coef_a <= '0;
      fail_count <= 0;
      expected_points.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MODULUS) field_mod <= cfg_data;
        else if (cfg_index == REG_CURVE_A) coef_a <= cfg_data;
      end
      if (in_tvalid && in_tready) expected_points.push_back(predict_point(in_tdata));
      if (out_tvalid && out_tready) begin
        got_pt = out_tdata[32:0];
        if (expected_points.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result beat %h", got_pt);
        end else begin
          exp_pt = expected_points.pop_front();
          if (got_pt !== exp_pt) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: rx %h/%h ry %h/%h no_inverse %b/%b (exp/got)",
                       exp_pt.rx, got_pt.rx, exp_pt.ry, got_pt.ry,
                       exp_pt.no_inv, got_pt.no_inv);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench top for ec_point_add_double_mod_p: clock, reset, config phases,
// directed and random point beats, receiver stalls, verdict. Depends on ecpa_pkg, ecpa_checker.
`default_nettype none
module tb_top;
  import ecpa_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = REG_MODULUS;
  logic [15:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_off = 0;
  int          quiet_cycles = 0;

  ec_point_add_double_mod_p dut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready, .out_tdata
  );

  ecpa_checker checker_i (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready, .out_tdata,
    .fail_count, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic send_point(logic op, logic [15:0] px, logic [15:0] py,
                            logic [15:0] qx, logic [15:0] qy);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, qy, qx, py, px, op};
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random(int count, logic [15:0] m);
    logic [15:0] px;
    logic [15:0] py;
    for (int i = 0; i < count; i++) begin
      px = 16'($urandom);
      py = 16'($urandom);
      case ($urandom_range(9))
        0: send_point(1'b0, px, py, px, py);
        1: send_point(1'b1, px, m, 16'($urandom), 16'($urandom));
        2: send_point(1'b0, px, py, px + m, 16'($urandom));
        3: send_point(1'($urandom), 16'($urandom_range(m)), 16'($urandom_range(m)),
                      16'($urandom_range(m)), 16'($urandom_range(m)));
        default: send_point(1'($urandom), px, py, 16'($urandom), 16'($urandom));
      endcase
    end
  endtask

  initial begin
    logic [15:0] mods[8];
    logic [15:0] coefs[8];
    mods  = '{16'd2, 16'd65521, 16'd65535, 16'd97, 16'd0, 16'd1, 16'd3, 16'd40961};
    coefs = '{16'd0, 16'd65535, 16'd7, 16'd200, 16'd5, 16'd1, 16'd65534, 16'd3};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_point(1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_point(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();
    write_reg(REG_MODULUS, 16'd97);
    write_reg(REG_CURVE_A, 16'd2);
    send_point(1'b0, 16'd3, 16'd6, 16'd80, 16'd10);
    send_point(1'b1, 16'd3, 16'd6, 16'd0, 16'd0);
    send_point(1'b0, 16'd5, 16'd9, 16'd5, 16'd9);
    send_point(1'b0, 16'd5, 16'd9, 16'd102, 16'd1);
    send_point(1'b1, 16'd5, 16'd0, 16'd0, 16'd0);
    send_point(1'b1, 16'd5, 16'd97, 16'd0, 16'd0);
    send_point(1'b0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    send_point(1'b1, 16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF);
    drain();
    write_reg(REG_MODULUS, 16'd0);
    send_point(1'b0, 16'd1, 16'd2, 16'd3, 16'd4);
    send_point(1'b1, 16'd1, 16'd2, 16'd3, 16'd4);
    drain();
    write_reg(REG_MODULUS, 16'd1);
    send_point(1'b1, 16'd9, 16'd9, 16'd9, 16'd9);
    drain();
    write_reg(REG_MODULUS, 16'd15);
    send_point(1'b0, 16'd1, 16'd2, 16'd4, 16'd7);
    send_point(1'b0, 16'd1, 16'd2, 16'd3, 16'd7);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_MODULUS, mods[ph]);
      write_reg(REG_CURVE_A, coefs[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 84; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 84; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      if (ph == 3) begin
        hold_off = 3000;
        send_idle_pct = 0;
      end
      send_random(ph == 7 ? 60 : 110, mods[ph]);
      if (ph == 2) begin
        send_idle_pct = 0;
        stall_pct = 0;
        send_random(40, mods[ph]);
      end
      drain();
    end
    send_idle_pct = 0;
    stall_pct = 0;
    write_reg(REG_MODULUS, 16'd65521);
    send_random(365, 16'd65521);
    drain();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== ec_point_add_double_mod_p.f =====
sv/ecpa_pkg.sv
sv/ecpa_datapath.sv
sv/ecpa_ctrl.sv
sv/ec_point_add_double_mod_p.sv
dv/ecpa_checker.sv
dv/tb_top.sv
